[sv/xcfr_pkg.sv]
package xcfr_pkg;

    localparam int FRAME_BYTES = 11;
    localparam logic [7:0] HEADER_RESET = 8'hA5;
    localparam logic [7:0] LEN_MAX = 8'hFF;

    localparam logic [7:0] POS_FIRST = 8'd0;
    localparam logic [7:0] POS_PITCH_LO = 8'd1;
    localparam logic [7:0] POS_PITCH_HI = 8'd4;
    localparam logic [7:0] POS_YAW_LO = 8'd5;
    localparam logic [7:0] POS_YAW_HI = 8'd8;
    localparam logic [7:0] POS_DETECTED = 8'(FRAME_BYTES - 2);
    localparam logic [7:0] POS_CHECKSUM = 8'(FRAME_BYTES - 1);
    localparam logic [7:0] FRAME_LEN = 8'(FRAME_BYTES);

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_BAD_HDR  = 2'd2,
        STATUS_BAD_CSUM = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  frame_len;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_bits;
        logic [7:0]  detected;
        logic [31:0] frames_total;
        logic [31:0] frames_good;
        logic [31:0] bad_length_count;
        logic [31:0] bad_header_count;
        logic [31:0] bad_checksum_count;
    } frame_result_t;

endpackage

[sv/xcfr_in_stage.sv]
module xcfr_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  xcfr_pkg::byte_item_t in_item,
    output logic                item_valid,
    output xcfr_pkg::byte_item_t item,
    input  logic                item_pop
);
    import xcfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    assign in_ready = !valid_reg || item_pop;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb begin
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (item_pop) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

[sv/xcfr_frame_core.sv]
module xcfr_frame_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             header_value,
    input  logic                   item_valid,
    input  xcfr_pkg::byte_item_t   item,
    output logic                   item_pop,
    input  logic                   result_free,
    output logic                   result_valid,
    output xcfr_pkg::frame_result_t result
);
    import xcfr_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  first_reg, first_next;
    logic [31:0] pitch_reg, pitch_next;
    logic [31:0] yaw_reg, yaw_next;
    logic [7:0]  det_reg, det_next;
    logic [7:0]  csum_reg, csum_next;
    logic [31:0] good_pitch_reg, good_pitch_next;
    logic [31:0] good_yaw_reg, good_yaw_next;
    logic [7:0]  good_det_reg, good_det_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_len_reg, bad_len_next;
    logic [31:0] bad_hdr_reg, bad_hdr_next;
    logic [31:0] bad_csum_reg, bad_csum_next;
    logic [7:0]  len;
    status_t     status;
    logic        frame_end;

    assign item_pop = item_valid && (!item.last_byte || result_free);
    assign frame_end = item_pop && item.last_byte;
    assign result_valid = frame_end;
    assign len = (pos_reg == LEN_MAX) ? LEN_MAX : pos_reg + 8'd1;

    always_comb begin
        first_next = first_reg;
        pitch_next = pitch_reg;
        yaw_next = yaw_reg;
        det_next = det_reg;
        csum_next = csum_reg;
        xor_next = xor_reg;
        if (pos_reg == POS_FIRST) begin
            first_next = item.data_byte;
        end else if (pos_reg inside {[POS_PITCH_LO:POS_PITCH_HI]}) begin
            pitch_next = {item.data_byte, pitch_reg[31:8]};
        end else if (pos_reg inside {[POS_YAW_LO:POS_YAW_HI]}) begin
            yaw_next = {item.data_byte, yaw_reg[31:8]};
        end else if (pos_reg == POS_DETECTED) begin
            det_next = item.data_byte;
        end else if (pos_reg == POS_CHECKSUM) begin
            csum_next = item.data_byte;
        end
        if (pos_reg inside {[POS_PITCH_LO:POS_DETECTED]}) begin
            xor_next = xor_reg ^ item.data_byte;
        end

        if (len != FRAME_LEN) begin
            status = STATUS_BAD_LEN;
        end else if (first_next != header_value) begin
            status = STATUS_BAD_HDR;
        end else if (xor_next != csum_next) begin
            status = STATUS_BAD_CSUM;
        end else begin
            status = STATUS_OK;
        end

        total_next = total_reg + 32'd1;
        good_next = good_reg;
        bad_len_next = bad_len_reg;
        bad_hdr_next = bad_hdr_reg;
        bad_csum_next = bad_csum_reg;
        good_pitch_next = good_pitch_reg;
        good_yaw_next = good_yaw_reg;
        good_det_next = good_det_reg;
        case (status)
            STATUS_OK: begin
                good_next = good_reg + 32'd1;
                good_pitch_next = pitch_next;
                good_yaw_next = yaw_next;
                good_det_next = det_next;
            end
            STATUS_BAD_LEN: begin
                bad_len_next = bad_len_reg + 32'd1;
            end
            STATUS_BAD_HDR: begin
                bad_hdr_next = bad_hdr_reg + 32'd1;
            end
            STATUS_BAD_CSUM: begin
                bad_csum_next = bad_csum_reg + 32'd1;
            end
            default: begin
                bad_len_next = bad_len_reg;
            end
        endcase

        pos_next = len;
    end

    always_comb begin
        result.status = status;
        result.frame_len = len;
        result.pitch_bits = good_pitch_next;
        result.yaw_bits = good_yaw_next;
        result.detected = good_det_next;
        result.frames_total = total_next;
        result.frames_good = good_next;
        result.bad_length_count = bad_len_next;
        result.bad_header_count = bad_hdr_next;
        result.bad_checksum_count = bad_csum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            xor_reg <= '0;
            first_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
            det_reg <= '0;
            csum_reg <= '0;
            good_pitch_reg <= '0;
            good_yaw_reg <= '0;
            good_det_reg <= '0;
            total_reg <= '0;
            good_reg <= '0;
            bad_len_reg <= '0;
            bad_hdr_reg <= '0;
            bad_csum_reg <= '0;
        end else if (frame_end) begin
            pos_reg <= '0;
            xor_reg <= '0;
            first_reg <= '0;
            pitch_reg <= '0;
            yaw_reg <= '0;
            det_reg <= '0;
            csum_reg <= '0;
            good_pitch_reg <= good_pitch_next;
            good_yaw_reg <= good_yaw_next;
            good_det_reg <= good_det_next;
            total_reg <= total_next;
            good_reg <= good_next;
            bad_len_reg <= bad_len_next;
            bad_hdr_reg <= bad_hdr_next;
            bad_csum_reg <= bad_csum_next;
        end else if (item_pop) begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
            first_reg <= first_next;
            pitch_reg <= pitch_next;
            yaw_reg <= yaw_next;
            det_reg <= det_next;
            csum_reg <= csum_next;
        end
    end

endmodule

[sv/xcfr_out_stage.sv]
module xcfr_out_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    result_valid,
    input  xcfr_pkg::frame_result_t result,
    output logic                    result_free,
    output logic                    out_valid,
    input  logic                    out_ready,
    output xcfr_pkg::frame_result_t out_result
);
    import xcfr_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    frame_result_t result_reg;

    assign result_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        if (result_valid) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_valid) begin
            result_reg <= result;
        end
    end

endmodule

[sv/xor_checked_frame_receiver.sv]
// Receives packets one byte per request on the s_ channel, with s_last_byte on the final byte,
// and delivers one status request per packet on the m_ channel: the status of the length,
// header and XOR checks, the packet length (saturating at 255), the pitch, yaw and detected
// fields of the last good frame, and five wrapping 32-bit packet counters. A byte is taken
// every cycle while the input does not stall; it passes an input register and is then folded
// into the packet state, and on the last byte the edge that folds it also loads the result
// into the output register, so a result passes both registers after its last byte is accepted.
// Input stalls only when the output register is held by m_ready low and a last byte needs it.
// The expected header byte is written through the cfg_ port (reset 0xA5) and should only be
// changed while no packet is in progress.
module xor_checked_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_frame_len,
    output logic [31:0] m_pitch_bits,
    output logic [31:0] m_yaw_bits,
    output logic [7:0]  m_detected,
    output logic [31:0] m_frames_total,
    output logic [31:0] m_frames_good,
    output logic [31:0] m_bad_length_count,
    output logic [31:0] m_bad_header_count,
    output logic [31:0] m_bad_checksum_count
);
    import xcfr_pkg::*;

    logic          header_write;
    logic [7:0]    header_value_reg;
    byte_item_t    in_item;
    byte_item_t    item;
    logic          item_valid;
    logic          item_pop;
    logic          result_free;
    logic          result_valid;
    frame_result_t result;
    frame_result_t out_result;

    assign header_write = cfg_valid;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_value_reg <= HEADER_RESET;
        end else if (header_write) begin
            header_value_reg <= cfg_data;
        end
    end

    assign in_item.data_byte = s_data_byte;
    assign in_item.last_byte = s_last_byte;

    xcfr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    xcfr_frame_core u_frame_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .header_value (header_value_reg),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .result_free  (result_free),
        .result_valid (result_valid),
        .result       (result)
    );

    xcfr_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .result_valid (result_valid),
        .result       (result),
        .result_free  (result_free),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_result   (out_result)
    );

    assign m_status = out_result.status;
    assign m_frame_len = out_result.frame_len;
    assign m_pitch_bits = out_result.pitch_bits;
    assign m_yaw_bits = out_result.yaw_bits;
    assign m_detected = out_result.detected;
    assign m_frames_total = out_result.frames_total;
    assign m_frames_good = out_result.frames_good;
    assign m_bad_length_count = out_result.bad_length_count;
    assign m_bad_header_count = out_result.bad_header_count;
    assign m_bad_checksum_count = out_result.bad_checksum_count;

endmodule

[sv/xcfr_checker.sv]
module xcfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [7:0]  m_frame_len,
    input logic [31:0] m_frames_total,
    input logic [31:0] m_frames_good,
    input logic [31:0] m_bad_length_count,
    input logic [31:0] m_bad_header_count,
    input logic [31:0] m_bad_checksum_count
);
    import xcfr_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_frames_total))
        else $error("stalled result changed");

    a_counters_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frames_total == 32'(m_frames_good + m_bad_length_count
            + m_bad_header_count + m_bad_checksum_count))
        else $error("packet counters do not add up");

    a_ok_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_OK |-> m_frame_len == FRAME_LEN)
        else $error("good frame with wrong length");

    a_bad_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_BAD_LEN |-> m_frame_len != FRAME_LEN)
        else $error("length error on a frame of correct length");

endmodule

bind xor_checked_frame_receiver xcfr_checker u_xcfr_checker (.*);

[sim/tb_xor_checked_frame_receiver.sv]
`timescale 1ns / 1ps

module tb_xor_checked_frame_receiver;
    import xcfr_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int IDLE_CYCLE_LIMIT = 1000;
    localparam int PHASE_BYTES = 330;
    localparam int PHASE_COUNT = 5;
    localparam int SETTLE_CYCLES = 4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_frame_len;
    logic [31:0] m_pitch_bits;
    logic [31:0] m_yaw_bits;
    logic [7:0]  m_detected;
    logic [31:0] m_frames_total;
    logic [31:0] m_frames_good;
    logic [31:0] m_bad_length_count;
    logic [31:0] m_bad_header_count;
    logic [31:0] m_bad_checksum_count;

    byte_item_t    pending_bytes[$];
    frame_result_t expected_results[$];
    int            queued_bytes = 0;
    int            error_count = 0;
    int            idle_cycles = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    bit            no_idle = 1'b0;

    logic [7:0]  header_reg = HEADER_RESET;
    logic [7:0]  rx_pos = '0;
    logic [7:0]  rx_xor = '0;
    logic [7:0]  rx_first = '0;
    logic [31:0] rx_pitch = '0;
    logic [31:0] rx_yaw = '0;
    logic [7:0]  rx_detected = '0;
    logic [7:0]  rx_checksum = '0;
    logic [31:0] latched_pitch = '0;
    logic [31:0] latched_yaw = '0;
    logic [7:0]  latched_detected = '0;
    logic [31:0] count_total = '0;
    logic [31:0] count_good = '0;
    logic [31:0] count_bad_length = '0;
    logic [31:0] count_bad_header = '0;
    logic [31:0] count_bad_checksum = '0;

    xor_checked_frame_receiver dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_last_byte         (s_last_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_frame_len         (m_frame_len),
        .m_pitch_bits        (m_pitch_bits),
        .m_yaw_bits          (m_yaw_bits),
        .m_detected          (m_detected),
        .m_frames_total      (m_frames_total),
        .m_frames_good       (m_frames_good),
        .m_bad_length_count  (m_bad_length_count),
        .m_bad_header_count  (m_bad_header_count),
        .m_bad_checksum_count(m_bad_checksum_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic void fold_received_byte(logic [7:0] data, logic last);
        frame_result_t r;
        if (rx_pos == POS_FIRST) begin
            rx_first = data;
        end else if (rx_pos <= POS_PITCH_HI) begin
            rx_pitch = {data, rx_pitch[31:8]};
        end else if (rx_pos <= POS_YAW_HI) begin
            rx_yaw = {data, rx_yaw[31:8]};
        end else if (rx_pos == POS_DETECTED) begin
            rx_detected = data;
        end else if (rx_pos == POS_CHECKSUM) begin
            rx_checksum = data;
        end
        if (rx_pos >= POS_PITCH_LO && rx_pos <= POS_DETECTED) begin
            rx_xor = rx_xor ^ data;
        end
        if (rx_pos != LEN_MAX) begin
            rx_pos = rx_pos + 8'd1;
        end
        if (!last) begin
            return;
        end
        count_total = count_total + 32'd1;
        if (rx_pos != FRAME_LEN) begin
            r.status = STATUS_BAD_LEN;
            count_bad_length = count_bad_length + 32'd1;
        end else if (rx_first != header_reg) begin
            r.status = STATUS_BAD_HDR;
            count_bad_header = count_bad_header + 32'd1;
        end else if (rx_xor != rx_checksum) begin
            r.status = STATUS_BAD_CSUM;
            count_bad_checksum = count_bad_checksum + 32'd1;
        end else begin
            r.status = STATUS_OK;
            count_good = count_good + 32'd1;
            latched_pitch = rx_pitch;
            latched_yaw = rx_yaw;
            latched_detected = rx_detected;
        end
        r.frame_len = rx_pos;
        r.pitch_bits = latched_pitch;
        r.yaw_bits = latched_yaw;
        r.detected = latched_detected;
        r.frames_total = count_total;
        r.frames_good = count_good;
        r.bad_length_count = count_bad_length;
        r.bad_header_count = count_bad_header;
        r.bad_checksum_count = count_bad_checksum;
        expected_results.push_back(r);
        rx_pos = '0;
        rx_xor = '0;
        rx_first = '0;
        rx_pitch = '0;
        rx_yaw = '0;
        rx_detected = '0;
        rx_checksum = '0;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    function automatic byte_q_t make_frame(logic [7:0] hdr, logic [7:0] fill, bit scramble);
        byte_q_t pkt;
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        pkt.push_back(hdr);
        for (int i = 1; i < FRAME_BYTES - 1; i++) begin
            b = scramble ? 8'($urandom) : fill;
            sum = sum ^ b;
            pkt.push_back(b);
        end
        pkt.push_back(sum);
        return pkt;
    endfunction

    task automatic queue_packet(byte_q_t pkt);
        byte_item_t item;
        foreach (pkt[i]) begin
            item.data_byte = pkt[i];
            item.last_byte = (i == pkt.size() - 1);
            pending_bytes.push_back(item);
        end
        queued_bytes += pkt.size();
    endtask

    task automatic queue_random_packet(logic [7:0] hdr);
        byte_q_t pkt;
        int unsigned pick;
        int unsigned keep;
        pick = $urandom_range(0, 99);
        pkt = make_frame(hdr, '0, 1'b1);
        if (pick < 55) begin
            // Well-formed frame.
        end else if (pick < 66) begin
            pkt[POS_FIRST] = pkt[POS_FIRST] ^ 8'($urandom_range(1, 255));
        end else if (pick < 77) begin
            pkt[POS_CHECKSUM] = pkt[POS_CHECKSUM] ^ 8'($urandom_range(1, 255));
        end else if (pick < 82) begin
            pkt[POS_FIRST] = pkt[POS_FIRST] ^ 8'($urandom_range(1, 255));
            pkt[POS_CHECKSUM] = pkt[POS_CHECKSUM] ^ 8'($urandom_range(1, 255));
        end else if (pick < 91) begin
            keep = $urandom_range(1, FRAME_BYTES - 1);
            while (pkt.size() > keep) begin
                void'(pkt.pop_back());
            end
            if ($urandom_range(0, 1) == 0) begin
                pkt[POS_FIRST] = 8'($urandom);
            end
        end else if (pick < 99) begin
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(245, 260)) pkt.push_back(8'($urandom));
        end
        queue_packet(pkt);
    endtask

    task automatic write_header(logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        byte_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data_byte <= '0;
            s_last_byte <= 1'b0;
            send_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 2);
                s_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                item = pending_bytes.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= item.data_byte;
                s_last_byte <= item.last_byte;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                header_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                fold_received_byte(s_data_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Unexpected status request: status %0d, frame_len %0d",
                           m_status, m_frame_len);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("frame_len", 32'(want.frame_len), 32'(m_frame_len));
                    check_field("pitch_bits", want.pitch_bits, m_pitch_bits);
                    check_field("yaw_bits", want.yaw_bits, m_yaw_bits);
                    check_field("detected", 32'(want.detected), 32'(m_detected));
                    check_field("frames_total", want.frames_total, m_frames_total);
                    check_field("frames_good", want.frames_good, m_frames_good);
                    check_field("bad_length_count", want.bad_length_count,
                                m_bad_length_count);
                    check_field("bad_header_count", want.bad_header_count,
                                m_bad_header_count);
                    check_field("bad_checksum_count", want.bad_checksum_count,
                                m_bad_checksum_count);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        byte_q_t pkt;
        logic [7:0] hdr;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The shortest packet, an all-ones frame and an all-zeros frame with a bad checksum.
        pkt = {8'h00};
        queue_packet(pkt);
        pkt = make_frame(HEADER_RESET, 8'hFF, 1'b0);
        queue_packet(pkt);
        pkt = make_frame(HEADER_RESET, 8'h00, 1'b0);
        pkt[POS_CHECKSUM] = pkt[POS_CHECKSUM] ^ 8'h01;
        queue_packet(pkt);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0) begin
                hdr = HEADER_RESET;
            end else begin
                wait_idle();
                case (phase)
                    1: begin
                        hdr = 8'h00;
                    end
                    2: begin
                        hdr = 8'hFF;
                    end
                    3: begin
                        hdr = 8'($urandom_range(1, 254));
                    end
                    default: begin
                        hdr = HEADER_RESET;
                    end
                endcase
                no_idle = (phase == PHASE_COUNT - 1);
                write_header(hdr);
                @(negedge aclk);
            end
            if (phase == 2) begin
                // A packet long enough to saturate the byte count.
                pkt = make_frame(hdr, '0, 1'b1);
                repeat (290) pkt.push_back(8'($urandom));
                queue_packet(pkt);
            end
            while (queued_bytes < (phase + 1) * PHASE_BYTES) begin
                queue_random_packet(hdr);
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/xcfr_pkg.sv
sv/xcfr_in_stage.sv
sv/xcfr_frame_core.sv
sv/xcfr_out_stage.sv
sv/xor_checked_frame_receiver.sv
sv/xcfr_checker.sv
sim/tb_xor_checked_frame_receiver.sv
